// ----- rtl/tcw_pkg.sv -----
// Shared types, constants and helpers of the text console writer.
package tcw_pkg;

  // Screen geometry
  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int NCELLS = COLS * ROWS;
  localparam int CELL_W = $clog2(NCELLS);

  // Field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 6;
  localparam int IDX_W  = 13;
  localparam int BYTE_W = 8;

  // Character and attribute codes
  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [BYTE_W-1:0] CH_ERROR     = 8'h45;
  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [BYTE_W-1:0] ATTR_WHITE   = 8'h0F;
  localparam logic [BYTE_W-1:0] ATTR_ERROR   = 8'hF4;

  typedef enum logic [1:0] {
    FUNC_PRINT = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_RSVD  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FLUSH,
    ST_ZERO,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    func_e              func;
    logic [BYTE_W-1:0]  char_code;
    logic [BYTE_W-1:0]  attr;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic               use_cursor;
  } tcw_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]   cursor_cell;
    logic               error;
    logic [BYTE_W-1:0]  cell_char;
    logic [BYTE_W-1:0]  cell_attr;
  } tcw_out_t;

  // Linear cell index row*COLS+col, kept at result width
  function automatic logic [IDX_W-1:0] cell_index(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return IDX_W'(r) * IDX_W'(COLS) + IDX_W'(c);
  endfunction

endpackage

// ----- rtl/tcw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/text_console_writer_unit.sv -----
// Text console writer: cell store sequencer, cursor and result staging.
//
// The block keeps one character byte and one attribute byte per screen cell in two
// single-port-write RAMs and a cursor as row and column registers. A plain print, a
// backspace, a newline, an off-screen print or read, or a reserved code is finished
// in ST_IDLE; a read passes through ST_READ to take the registered RAM read data.
// A print that runs off the last row scrolls: one cell per cycle is copied up through
// the RAM read port, then the last row is zeroed. A clear rewrites every character
// through the write port. After reset a clearing pass zeroes the store before the
// first item is taken. A result waits in a holding register while the output
// register is stalled, so one further item can be accepted behind a stalled result.
module text_console_writer_unit
  import tcw_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tcw_in_t  in_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output tcw_out_t out_o
);

  state_e state_q, state_d;
  logic [CELL_W-1:0] cnt_q, cnt_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic              copy_vld_q, copy_vld_d;
  logic [CELL_W-1:0] copy_addr_q, copy_addr_d;
  logic              pend_vld_q, pend_vld_d;
  tcw_out_t          pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  tcw_out_t          out_q, out_d;

  logic              acc, done, cnt_end, out_free;
  logic              off, is_nl, is_bs, wrap;
  logic [ROW_W-1:0]  p_row, n_row;
  logic [COL_W-1:0]  p_col, n_col;
  logic [ROW_W:0]    n_row_raw;
  logic [BYTE_W-1:0] attr_eff;
  logic [IDX_W-1:0]  given_idx, new_idx, cur_idx;
  logic [CELL_W-1:0] pos_idx;

  logic              we_char, we_attr;
  logic [CELL_W-1:0] waddr, raddr;
  logic [BYTE_W-1:0] wchar, wattr, rchar, rattr;

  // Decode the incoming beat
  assign acc      = in_valid_i && in_ready_o;
  assign cnt_end  = (cnt_q == CELL_W'(NCELLS - 1));
  assign off      = !in_i.use_cursor &&
                    ((in_i.col >= COL_W'(COLS)) || (in_i.row >= ROW_W'(ROWS)));
  assign p_row    = in_i.use_cursor ? cur_row_q : in_i.row;
  assign p_col    = in_i.use_cursor ? cur_col_q : in_i.col;
  assign is_nl    = (in_i.char_code == CH_NEWLINE);
  assign is_bs    = (in_i.char_code == CH_BACKSPACE);
  assign attr_eff = (in_i.attr == '0) ? ATTR_WHITE : in_i.attr;

  // Advance the print position
  always_comb begin
    if (is_nl) begin
      n_row_raw = {1'b0, p_row} + 1'b1;
      n_col     = '0;
    end else if (is_bs) begin
      n_row_raw = {1'b0, p_row};
      n_col     = p_col;
    end else if (p_col == COL_W'(COLS - 1)) begin
      n_row_raw = {1'b0, p_row} + 1'b1;
      n_col     = '0;
    end else begin
      n_row_raw = {1'b0, p_row};
      n_col     = p_col + 1'b1;
    end
  end

  assign wrap      = (n_row_raw == (ROW_W + 1)'(ROWS));
  assign n_row     = wrap ? ROW_W'(ROWS - 1) : n_row_raw[ROW_W-1:0];
  assign given_idx = cell_index(in_i.row, in_i.col);
  assign pos_idx   = CELL_W'(cell_index(p_row, p_col));
  assign new_idx   = cell_index(n_row, n_col);
  assign cur_idx   = cell_index(cur_row_q, cur_col_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (cnt_end) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc) begin
          case (in_i.func)
            FUNC_PRINT: state_d = (!off && wrap) ? ST_SCROLL : ST_IDLE;
            FUNC_CLEAR: state_d = ST_CLEAR;
            FUNC_READ:  state_d = off ? ST_IDLE : ST_READ;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ:   state_d = ST_IDLE;
      ST_SCROLL: begin
        if (cnt_end) state_d = ST_FLUSH;
      end
      ST_FLUSH:  state_d = ST_ZERO;
      ST_ZERO: begin
        if (cnt_end) state_d = ST_IDLE;
      end
      ST_CLEAR: begin
        if (cnt_end) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Store access, cursor, sweep counter and result payload
  always_comb begin
    we_char     = 1'b0;
    we_attr     = 1'b0;
    waddr       = cnt_q;
    wchar       = '0;
    wattr       = '0;
    raddr       = cnt_q;
    cnt_d       = cnt_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    copy_vld_d  = 1'b0;
    copy_addr_d = copy_addr_q;
    pend_d      = pend_q;
    done        = 1'b0;

    case (state_q)
      ST_INIT: begin
        we_char = 1'b1;
        we_attr = 1'b1;
        cnt_d   = cnt_q + 1'b1;
      end
      ST_IDLE: begin
        raddr = pos_idx;
        if (acc) begin
          pend_d = '{cursor_cell: cur_idx, error: 1'b0, cell_char: '0, cell_attr: '0};
          case (in_i.func)
            FUNC_PRINT: begin
              if (off) begin
                we_char            = 1'b1;
                we_attr            = 1'b1;
                waddr              = CELL_W'(NCELLS - 1);
                wchar              = CH_ERROR;
                wattr              = ATTR_ERROR;
                pend_d.cursor_cell = given_idx;
                pend_d.error       = 1'b1;
                done               = 1'b1;
              end else begin
                we_char            = !is_nl;
                we_attr            = !is_nl;
                waddr              = pos_idx;
                wchar              = is_bs ? CH_SPACE : in_i.char_code;
                wattr              = attr_eff;
                cur_row_d          = n_row;
                cur_col_d          = n_col;
                pend_d.cursor_cell = new_idx;
                cnt_d              = CELL_W'(COLS);
                done               = !wrap;
              end
            end
            FUNC_CLEAR: begin
              cur_row_d          = '0;
              cur_col_d          = '0;
              pend_d.cursor_cell = '0;
              cnt_d              = '0;
            end
            FUNC_READ: begin
              if (off) begin
                pend_d.cursor_cell = given_idx;
                pend_d.error       = 1'b1;
                done               = 1'b1;
              end else begin
                pend_d.cursor_cell = IDX_W'(pos_idx);
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        pend_d.cell_char = rchar;
        pend_d.cell_attr = rattr;
        done             = 1'b1;
      end
      ST_SCROLL: begin
        copy_vld_d  = 1'b1;
        copy_addr_d = cnt_q - CELL_W'(COLS);
        cnt_d       = cnt_q + 1'b1;
      end
      ST_FLUSH: begin
        cnt_d = CELL_W'(NCELLS - COLS);
      end
      ST_ZERO: begin
        we_char = 1'b1;
        we_attr = 1'b1;
        cnt_d   = cnt_q + 1'b1;
        done    = cnt_end;
      end
      ST_CLEAR: begin
        we_char = 1'b1;
        wchar   = CH_SPACE;
        cnt_d   = cnt_q + 1'b1;
        done    = cnt_end;
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase

    // Write back the cell copied up one row during a scroll
    if (copy_vld_q) begin
      we_char = 1'b1;
      we_attr = 1'b1;
      waddr   = copy_addr_q;
      wchar   = rchar;
      wattr   = rattr;
    end
  end

  // Stage results: holding register, then output register
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    pend_vld_d  = pend_vld_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (pend_vld_q && out_free) begin
      out_valid_d = 1'b1;
      out_d       = pend_q;
      pend_vld_d  = 1'b0;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (done) pend_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      copy_vld_q  <= 1'b0;
      pend_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      copy_vld_q  <= copy_vld_d;
      pend_vld_q  <= pend_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    copy_addr_q <= copy_addr_d;
    pend_q      <= pend_d;
    out_q       <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE) && !pend_vld_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Character and attribute stores
  tcw_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (NCELLS)
  ) u_char_ram (
    .clk_i   (clk_i),
    .we_i    (we_char),
    .waddr_i (waddr),
    .wdata_i (wchar),
    .raddr_i (raddr),
    .rdata_o (rchar)
  );

  tcw_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (NCELLS)
  ) u_attr_ram (
    .clk_i   (clk_i),
    .we_i    (we_attr),
    .waddr_i (waddr),
    .wdata_i (wattr),
    .raddr_i (raddr),
    .rdata_o (rattr)
  );

  // Cursor always points inside the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_row_q < ROW_W'(ROWS)) && (cur_col_q < COL_W'(COLS)))
    else $error("cursor outside the screen");

  // A held result is not dropped while the output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q && out_valid_q && !out_ready_i |=> pend_vld_q)
    else $error("held result lost under stall");

  // An item completes only into an empty holding register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !pend_vld_q)
    else $error("result overwrites a held result");

  // The flush cycle always carries the last copy of a scroll
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |-> copy_vld_q)
    else $error("scroll flush without pending copy");

  // No beat is taken during a sweep or a read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o)
    else $error("input taken while store is busy");

endmodule
